@@ rtl/core/pfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types and constants of the pixel fit placer: register indexes,
// reset values and the item that the queue carries from front to back.
// ----------------------------------------------------------------------------
package pfp_pkg;

	localparam int DIM_W   = 12;
	localparam int PIX_W   = 16;
	localparam int ADDR_W  = 16;
	localparam int ART_MAX = 1024;
	localparam int DST_W   = $clog2(ART_MAX);
	localparam int NUM_W   = DIM_W + $clog2(ART_MAX + 1);

	localparam logic REG_SOURCE_WIDTH  = 1'b0;
	localparam logic REG_SOURCE_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] SOURCE_DIM_RESET = 12'd256;

	typedef struct packed {
		logic             centre;
		logic             ok_x;
		logic             ok_y;
		logic [DST_W-1:0] dst_x;
		logic [DST_W-1:0] dst_y;
		logic [NUM_W-1:0] num_x;
		logic [NUM_W-1:0] num_y;
		logic [PIX_W-1:0] pixel;
	} pfp_item_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} pfp_queue_status_t;

endpackage

@@ rtl/core/pfp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_front
// Classifies one source pixel: centring or scaling, source range checks,
// the centred destination and the scaled numerators for the divider.
// ----------------------------------------------------------------------------
module pfp_front #(
	parameter int ART_SIZE = 256
) (
	input  logic [pfp_pkg::DIM_W-1:0] source_width,
	input  logic [pfp_pkg::DIM_W-1:0] source_height,
	input  logic [pfp_pkg::DIM_W-1:0] src_x,
	input  logic [pfp_pkg::DIM_W-1:0] src_y,
	input  logic [pfp_pkg::PIX_W-1:0] pixel_in,
	output pfp_pkg::pfp_item_t        item
);
	import pfp_pkg::*;

	localparam int SW = DIM_W + 2;

	typedef struct packed {
		logic             in_frame;
		logic [DST_W-1:0] dst;
	} pfp_centre_t;

	function automatic pfp_centre_t centre_axis(input logic [DIM_W-1:0] src,
			input logic [DIM_W-1:0] dim);
		logic signed [SW-1:0] diff;
		logic signed [SW-1:0] off;
		logic signed [SW-1:0] dst;
		pfp_centre_t          res;
		diff = SW'(ART_SIZE) - signed'({2'b00, dim});
		off  = (diff + signed'(SW'(diff[SW-1]))) >>> 1;
		dst  = signed'({2'b00, src}) + off;
		res.in_frame = !dst[SW-1] && (dst < SW'(ART_SIZE));
		res.dst      = dst[DST_W-1:0];
		return res;
	endfunction

	pfp_centre_t cx;
	pfp_centre_t cy;
	logic        centre;
	logic        in_x;
	logic        in_y;

	assign centre = (source_width < DIM_W'(ART_SIZE)) || (source_height < DIM_W'(ART_SIZE));
	assign in_x   = src_x < source_width;
	assign in_y   = src_y < source_height;
	assign cx     = centre_axis(src_x, source_width);
	assign cy     = centre_axis(src_y, source_height);

	always_comb begin
		item.centre = centre;
		item.ok_x   = in_x && (!centre || cx.in_frame);
		item.ok_y   = in_y && (!centre || cy.in_frame);
		item.dst_x  = cx.dst;
		item.dst_y  = cy.dst;
		item.num_x  = NUM_W'(src_x) * NUM_W'(ART_SIZE);
		item.num_y  = NUM_W'(src_y) * NUM_W'(ART_SIZE);
		item.pixel  = pixel_in;
	end

endmodule

@@ rtl/core/pfp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_queue
// Two-entry queue between the front and the back, one beat in (while not
// full) and one beat out (while not empty) per cycle.
// ----------------------------------------------------------------------------
module pfp_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  pfp_pkg::pfp_item_t         item_in,
	input  logic                       pop,
	output pfp_pkg::pfp_item_t         head,
	output pfp_pkg::pfp_queue_status_t status
);
	import pfp_pkg::*;

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	pfp_item_t       entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign status.not_empty = count_q != '0;
	assign status.full      = count_q == CW'(DEPTH);
	assign do_push          = push && !status.full;
	assign do_pop           = pop && status.not_empty;
	assign head             = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/pfp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_back
// Pipelined restoring divider for both axes, one quotient bit per stage,
// then the destination select and the frame address.
// ----------------------------------------------------------------------------
module pfp_back #(
	parameter int ART_SIZE = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [pfp_pkg::DIM_W-1:0]  source_width,
	input  logic [pfp_pkg::DIM_W-1:0]  source_height,
	input  logic                       in_valid,
	input  pfp_pkg::pfp_item_t         item_in,
	output logic                       done,
	output logic                       write_enable,
	output logic [pfp_pkg::ADDR_W-1:0] frame_address,
	output logic [pfp_pkg::PIX_W-1:0]  pixel_out
);
	import pfp_pkg::*;

	localparam int QW = $clog2(ART_SIZE);

	pfp_item_t     item_s [QW+1];
	logic [QW-1:0] qx_s   [QW+1];
	logic [QW-1:0] qy_s   [QW+1];
	logic          vld_s  [QW+1];

	logic [QW-1:0] dx;
	logic [QW-1:0] dy;
	logic          hit;
	logic [31:0]   addr_wide;

	always_ff @(posedge clk) begin
		item_s[0] <= item_in;
		qx_s[0]   <= '0;
		qy_s[0]   <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int B = QW - 1 - k;
		logic [NUM_W-1:0] dvx;
		logic [NUM_W-1:0] dvy;
		logic             ge_x;
		logic             ge_y;
		pfp_item_t        nxt_item;

		assign dvx  = NUM_W'(source_width) << B;
		assign dvy  = NUM_W'(source_height) << B;
		assign ge_x = item_s[k].num_x >= dvx;
		assign ge_y = item_s[k].num_y >= dvy;

		always_comb begin
			nxt_item = item_s[k];
			if (ge_x) begin
				nxt_item.num_x = item_s[k].num_x - dvx;
			end
			if (ge_y) begin
				nxt_item.num_y = item_s[k].num_y - dvy;
			end
		end

		always_ff @(posedge clk) begin
			item_s[k+1] <= nxt_item;
			qx_s[k+1]   <= {qx_s[k][QW-2:0], ge_x};
			qy_s[k+1]   <= {qy_s[k][QW-2:0], ge_y};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	assign dx        = item_s[QW].centre ? item_s[QW].dst_x[QW-1:0] : qx_s[QW];
	assign dy        = item_s[QW].centre ? item_s[QW].dst_y[QW-1:0] : qy_s[QW];
	assign hit       = item_s[QW].ok_x && item_s[QW].ok_y;
	assign addr_wide = 32'(dy) * 32'(ART_SIZE) + 32'(dx);

	always_ff @(posedge clk) begin
		write_enable  <= hit;
		frame_address <= hit ? addr_wide[ADDR_W-1:0] : '0;
		pixel_out     <= item_s[QW].pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[QW];
		end
	end

endmodule

@@ rtl/core/pixel_fit_placer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_fit_placer
// Places one RGB565 source pixel into a square ART_SIZE frame, centred when
// a source side is shorter than the frame, else downscaled nearest-neighbor.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------
//  pixel in | src_x, src_y, pixel_in                  | start high, busy low
//  result   | write_enable, frame_address, pixel_out  | done, one cycle
//  config   | cfg_write, cfg_index, cfg_data          | cfg_write, no wait
//
// One beat accepted per cycle; each result passes the queue, the divider input
// register, the one-bit-per-stage divider pipeline and the output registers.
// Reset clears the pipeline valid flags and the queue and sets both dimensions to 256.
// The receiver cannot stall; the queue drains every cycle, so busy stays low.
// ----------------------------------------------------------------------------
module pixel_fit_placer #(
	parameter int ART_SIZE = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic                       cfg_index,
	input  logic [pfp_pkg::DIM_W-1:0]  cfg_data,
	input  logic                       start,
	output logic                       busy,
	input  logic [pfp_pkg::DIM_W-1:0]  src_x,
	input  logic [pfp_pkg::DIM_W-1:0]  src_y,
	input  logic [pfp_pkg::PIX_W-1:0]  pixel_in,
	output logic                       done,
	output logic                       write_enable,
	output logic [pfp_pkg::ADDR_W-1:0] frame_address,
	output logic [pfp_pkg::PIX_W-1:0]  pixel_out
);
	import pfp_pkg::*;

	logic [DIM_W-1:0]  source_width_q;
	logic [DIM_W-1:0]  source_height_q;
	pfp_item_t         front_item;
	pfp_item_t         head;
	pfp_queue_status_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= SOURCE_DIM_RESET;
			source_height_q <= SOURCE_DIM_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SOURCE_WIDTH:  source_width_q  <= cfg_data;
				REG_SOURCE_HEIGHT: source_height_q <= cfg_data;
			endcase
		end
	end

	assign busy = qstat.full;

	pfp_front #(
		.ART_SIZE(ART_SIZE)
	) u_front (
		.source_width (source_width_q),
		.source_height(source_height_q),
		.src_x        (src_x),
		.src_y        (src_y),
		.pixel_in     (pixel_in),
		.item         (front_item)
	);

	pfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (start && !busy),
		.item_in(front_item),
		.pop    (qstat.not_empty),
		.head   (head),
		.status (qstat)
	);

	pfp_back #(
		.ART_SIZE(ART_SIZE)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.source_width (source_width_q),
		.source_height(source_height_q),
		.in_valid     (qstat.not_empty),
		.item_in      (head),
		.done         (done),
		.write_enable (write_enable),
		.frame_address(frame_address),
		.pixel_out    (pixel_out)
	);

endmodule
